// ----- rtl/pld_pkg.sv -----
// Package for the port load watchdog: field widths, register indexes,
// limits and the sequencer state type. Depends on nothing.
package pld_pkg;

  localparam int PORT_W  = 4;
  localparam int VOLT_W  = 16;
  localparam int CURR_W  = 14;
  localparam int PW      = 17;
  localparam int PROD_W  = VOLT_W + CURR_W;
  localparam int DIV_W   = PROD_W;
  localparam int DVS_W   = 14;
  localparam int WLEN_W  = 9;
  localparam int THR_W   = 17;
  localparam int MASK_W  = 8;
  localparam int CFG_AW  = 5;
  localparam int REG_W   = 3;

  localparam logic [DVS_W-1:0]  POWER_DIV   = 14'd10000;
  localparam logic [WLEN_W-1:0] WIN_MIN     = 9'd15;
  localparam logic [WLEN_W-1:0] WIN_MAX     = 9'd300;
  localparam logic [THR_W-1:0]  THR_DEFAULT = 17'd1000;
  localparam logic [THR_W-1:0]  THR_MAX     = 17'd100000;

  localparam int NUM_PORTS_DEF    = 8;
  localparam int WINDOW_DEPTH_DEF = 512;
  localparam int RECORD_LEN_DEF   = 10;

  localparam logic [REG_W-1:0] REG_WINDOW_LEN  = 3'd0;
  localparam logic [REG_W-1:0] REG_THRESHOLD   = 3'd1;
  localparam logic [REG_W-1:0] REG_RECORD_EN   = 3'd2;
  localparam logic [REG_W-1:0] REG_AUTO_MODE   = 3'd3;
  localparam logic [REG_W-1:0] REG_ENABLE_MASK = 3'd4;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_MULP = 10'b0000000010,
    S_DIVP = 10'b0000000100,
    S_WR   = 10'b0000001000,
    S_DIVR = 10'b0000010000,
    S_SUM  = 10'b0000100000,
    S_MULT = 10'b0001000000,
    S_DIVA = 10'b0010000000,
    S_EVAL = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_e;

endpackage

// ----- rtl/pld_if.sv -----
// Stream interfaces for the sample beats in and the result beats out.
// Depends on pld_pkg for the field widths.
interface pld_in_if import pld_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PORT_W-1:0] port;
  logic              port_on;
  logic [VOLT_W-1:0] voltage_mv;
  logic [CURR_W-1:0] current_tenth_ma;

  modport source(output valid, port, port_on, voltage_mv, current_tenth_ma, input ready);
  modport sink(input valid, port, port_on, voltage_mv, current_tenth_ma, output ready);
endinterface

interface pld_out_if import pld_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PORT_W-1:0] port_out;
  logic [PW-1:0]     power_mw;
  logic [PW-1:0]     average_mw;
  logic              power_cycle;
  logic              disable_request;
  logic              enable_request;
  logic              load_present;
  logic              window_full;
  logic              record_valid;
  logic [PW-1:0]     record_avg_mw;

  modport source(output valid, port_out, power_mw, average_mw, power_cycle, disable_request,
                 enable_request, load_present, window_full, record_valid, record_avg_mw,
                 input ready);
  modport sink(input valid, port_out, power_mw, average_mw, power_cycle, disable_request,
               enable_request, load_present, window_full, record_valid, record_avg_mw,
               output ready);
endinterface

// ----- rtl/pld_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on pld_pkg for the operand widths.
module pld_div import pld_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             busy_o,
  output logic [DIV_W-1:0] quot_o
);
  localparam int CW = $clog2(DIV_W + 1);

  logic [DVS_W-1:0] rem_q, dvs_q;
  logic [DIV_W-1:0] quo_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q;
  logic [DVS_W:0]   trial, diff;
  logic             ge;

  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      dvs_q  <= '0;
      quo_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else if (start_i) begin
      rem_q  <= '0;
      dvs_q  <= divisor_i;
      quo_q  <= dividend_i;
      cnt_q  <= CW'(DIV_W);
      busy_q <= 1'b1;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], ge};
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;
endmodule

// ----- rtl/poe_port_load_watchdog.sv -----
// Port load watchdog: one sample beat in, one result beat out, per valid port.
// For a powered port the work is two serial multiplies, two serial divides and a read of the n
// samples averaged from the window. A completed record adds a serial divide; a port that is off
// skips the window read, the second multiply and the average divide. The next sample can be
// taken in the cycle after the result beat is registered.
// Reset is asynchronous and active low; it clears counters, flags and registers, not the memory or its read data.
module poe_port_load_watchdog import pld_pkg::*; #(
  parameter int NUM_PORTS    = NUM_PORTS_DEF,
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
  parameter int RECORD_LEN   = RECORD_LEN_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  pld_in_if.sink            in_i,
  pld_out_if.source         out_o
);
  localparam int PIDX_W    = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam int NW        = $clog2(WINDOW_DEPTH + 1);
  localparam int IW        = $clog2(WINDOW_DEPTH);
  localparam int SW        = PW + NW;
  localparam int MEM_DEPTH = NUM_PORTS * WINDOW_DEPTH;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int RCW       = $clog2(RECORD_LEN + 1);
  localparam int RSW       = PW + RCW;
  localparam int MCW       = $clog2(CURR_W + 1);

  // Configuration registers.
  logic [WLEN_W-1:0] wlen_q;
  logic [THR_W-1:0]  thr_q;
  logic              rec_en_q, auto_q;
  logic [MASK_W-1:0] mask_q;
  logic [REG_W-1:0]  reg_idx;
  logic [WLEN_W-1:0] wlen_v;
  logic [THR_W-1:0]  thr_v;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_AW-1:2];
  assign wlen_v  = pwdata[WLEN_W-1:0];
  assign thr_v   = pwdata[THR_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q   <= WIN_MIN;
      thr_q    <= THR_DEFAULT;
      rec_en_q <= 1'b0;
      auto_q   <= 1'b0;
      mask_q   <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_WINDOW_LEN:  wlen_q <= (wlen_v < WIN_MIN || wlen_v > WIN_MAX) ? WIN_MIN : wlen_v;
        REG_THRESHOLD:   thr_q <= (thr_v > THR_MAX) ? THR_DEFAULT : thr_v;
        REG_RECORD_EN:   rec_en_q <= pwdata[0];
        REG_AUTO_MODE:   auto_q <= pwdata[0];
        REG_ENABLE_MASK: mask_q <= pwdata[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WINDOW_LEN:  prdata = 32'(wlen_q);
      REG_THRESHOLD:   prdata = 32'(thr_q);
      REG_RECORD_EN:   prdata = 32'(rec_en_q);
      REG_AUTO_MODE:   prdata = 32'(auto_q);
      REG_ENABLE_MASK: prdata = 32'(mask_q);
      default:         prdata = '0;
    endcase
  end

  // Per-port state.
  logic [NW-1:0]  cnt_q    [NUM_PORTS];
  logic           filled_q [NUM_PORTS];
  logic           load_q   [NUM_PORTS];
  logic [RSW-1:0] rsum_q   [NUM_PORTS];
  logic [RCW-1:0] rcnt_q   [NUM_PORTS];

  // Sample memory.
  logic [PW-1:0] mem [MEM_DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr, rd_addr;
  logic [PW-1:0] rd_data_q;

  // Sequencer and datapath.
  state_e             state_q;
  logic [PORT_W-1:0]  port_q;
  logic [PIDX_W-1:0]  p_q;
  logic               on_q;
  logic [AW-1:0]      base_q;
  logic [NW-1:0]      eff_q, n_q, ridx_q;
  logic [PROD_W-1:0]  mc_q, macc_q, macc_next;
  logic [CURR_W-1:0]  mp_q;
  logic [MCW-1:0]     mcnt_q;
  logic [PW-1:0]      pw_q, avg_q, rec_avg_q;
  logic               rec_valid_q, rvld_q;
  logic [SW-1:0]      sum_q;
  logic               out_valid_q;
  logic [PORT_W-1:0]  o_port_q;
  logic [PW-1:0]      o_pw_q, o_avg_q, o_rec_q;
  logic               o_cyc_q, o_dis_q, o_ena_q, o_load_q, o_full_q, o_recv_q;
  logic               res_cyc_q, res_dis_q, res_ena_q, res_load_q, res_full_q;

  logic               accept, port_ok, mul_last, issue;
  logic [PIDX_W-1:0]  pidx;
  logic [NW-1:0]      eff_in;
  logic [IW-1:0]      wr_idx;
  logic [RSW-1:0]     wr_rs;
  logic [RCW-1:0]     wr_rc;
  logic               wr_rdone;
  logic               div_start, div_busy;
  logic [DIV_W-1:0]   div_dvd, div_quot;
  logic [DVS_W-1:0]   div_dvs;
  logic [NW-1:0]      ev_cnt;
  logic               ev_fil, ev_ld, ev_cyc, ev_dis, ev_ena, ev_below, want;

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign port_ok    = (in_i.port != '0) && (5'(in_i.port) <= 5'(NUM_PORTS));
  assign pidx       = PIDX_W'(in_i.port - PORT_W'(1));
  assign eff_in     = ({1'b0, wlen_q} > 10'(WINDOW_DEPTH)) ? NW'(WINDOW_DEPTH) : NW'(wlen_q);
  assign macc_next  = mp_q[0] ? macc_q + mc_q : macc_q;
  assign mul_last   = (mcnt_q == MCW'(1));
  assign issue      = ridx_q < n_q;

  always_comb begin
    wr_idx   = (cnt_q[p_q] < eff_q) ? IW'(cnt_q[p_q]) : '0;
    wr_rs    = rsum_q[p_q] + RSW'(pw_q);
    wr_rc    = rcnt_q[p_q] + RCW'(1);
    wr_rdone = rec_en_q && (wr_rc >= RCW'(RECORD_LEN));
  end

  assign mem_we    = (state_q == S_WR);
  assign mem_waddr = base_q + AW'(wr_idx);
  assign rd_addr   = base_q + AW'(ridx_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= pw_q;
    end
    rd_data_q <= mem[rd_addr];
  end

  always_comb begin
    div_start = 1'b0;
    div_dvd   = DIV_W'(macc_next);
    div_dvs   = POWER_DIV;
    case (state_q)
      S_MULP: div_start = mul_last;
      S_WR: begin
        div_start = wr_rdone;
        div_dvd   = DIV_W'(wr_rs);
        div_dvs   = DVS_W'(RECORD_LEN);
      end
      S_MULT: begin
        div_start = mul_last;
        div_dvd   = DIV_W'(sum_q);
        div_dvs   = DVS_W'(n_q);
      end
      default: ;
    endcase
  end

  pld_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .quot_o     (div_quot)
  );

  always_comb begin
    ev_cnt   = cnt_q[p_q];
    ev_fil   = filled_q[p_q];
    ev_ld    = load_q[p_q];
    ev_cyc   = 1'b0;
    ev_dis   = 1'b0;
    ev_ena   = 1'b0;
    want     = (4'(p_q) < 4'd8) ? mask_q[3'(p_q)] : 1'b0;
    ev_below = DIV_W'(sum_q) < macc_q;
    if (on_q) begin
      if (ev_below && ev_fil && ev_ld) begin
        ev_ld  = 1'b0;
        ev_fil = 1'b0;
        ev_cnt = '0;
        ev_cyc = 1'b1;
      end else if (!ev_below) begin
        ev_ld = 1'b1;
      end
      if (ev_cnt == eff_q) begin
        ev_fil = 1'b1;
      end
      ev_dis = auto_q && !want;
    end else begin
      ev_cnt = '0;
      ev_fil = 1'b0;
      ev_ld  = 1'b0;
      ev_ena = auto_q && want;
    end
    if (ev_cnt == eff_q) begin
      ev_cnt = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      for (int i = 0; i < NUM_PORTS; i++) begin
        cnt_q[i]    <= '0;
        filled_q[i] <= 1'b0;
        load_q[i]   <= 1'b0;
        rsum_q[i]   <= '0;
        rcnt_q[i]   <= '0;
      end
      port_q      <= '0;
      p_q         <= '0;
      on_q        <= 1'b0;
      base_q      <= '0;
      eff_q       <= '0;
      n_q         <= '0;
      ridx_q      <= '0;
      mc_q        <= '0;
      macc_q      <= '0;
      mp_q        <= '0;
      mcnt_q      <= '0;
      pw_q        <= '0;
      avg_q       <= '0;
      rec_avg_q   <= '0;
      rec_valid_q <= 1'b0;
      rvld_q      <= 1'b0;
      sum_q       <= '0;
      res_cyc_q   <= 1'b0;
      res_dis_q   <= 1'b0;
      res_ena_q   <= 1'b0;
      res_load_q  <= 1'b0;
      res_full_q  <= 1'b0;
      out_valid_q <= 1'b0;
      o_port_q    <= '0;
      o_pw_q      <= '0;
      o_avg_q     <= '0;
      o_rec_q     <= '0;
      o_cyc_q     <= 1'b0;
      o_dis_q     <= 1'b0;
      o_ena_q     <= 1'b0;
      o_load_q    <= 1'b0;
      o_full_q    <= 1'b0;
      o_recv_q    <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept && port_ok) begin
            port_q      <= in_i.port;
            p_q         <= pidx;
            on_q        <= in_i.port_on;
            base_q      <= AW'(AW'(pidx) * AW'(WINDOW_DEPTH));
            eff_q       <= eff_in;
            mc_q        <= PROD_W'(in_i.voltage_mv);
            mp_q        <= in_i.current_tenth_ma;
            macc_q      <= '0;
            mcnt_q      <= MCW'(CURR_W);
            avg_q       <= '0;
            rec_avg_q   <= '0;
            rec_valid_q <= 1'b0;
            state_q     <= S_MULP;
          end
        end
        S_MULP, S_MULT: begin
          macc_q <= macc_next;
          mc_q   <= {mc_q[PROD_W-2:0], 1'b0};
          mp_q   <= {1'b0, mp_q[CURR_W-1:1]};
          mcnt_q <= mcnt_q - MCW'(1);
          if (mul_last) begin
            state_q <= (state_q == S_MULP) ? S_DIVP : S_DIVA;
          end
        end
        S_DIVP: begin
          if (!div_busy) begin
            pw_q    <= on_q ? div_quot[PW-1:0] : '0;
            state_q <= S_WR;
          end
        end
        S_WR: begin
          cnt_q[p_q] <= NW'(wr_idx) + NW'(1);
          n_q        <= filled_q[p_q] ? eff_q : NW'(wr_idx) + NW'(1);
          ridx_q     <= '0;
          rvld_q     <= 1'b0;
          sum_q      <= '0;
          if (rec_en_q) begin
            rsum_q[p_q] <= wr_rdone ? '0 : wr_rs;
            rcnt_q[p_q] <= wr_rdone ? '0 : wr_rc;
          end
          rec_valid_q <= wr_rdone;
          if (wr_rdone) begin
            state_q <= S_DIVR;
          end else begin
            state_q <= on_q ? S_SUM : S_EVAL;
          end
        end
        S_DIVR: begin
          if (!div_busy) begin
            rec_avg_q <= div_quot[PW-1:0];
            state_q   <= on_q ? S_SUM : S_EVAL;
          end
        end
        S_SUM: begin
          rvld_q <= issue;
          if (issue) begin
            ridx_q <= ridx_q + NW'(1);
          end
          if (rvld_q) begin
            sum_q <= sum_q + SW'(rd_data_q);
          end
          if (!issue && !rvld_q) begin
            mc_q    <= PROD_W'(thr_q);
            mp_q    <= CURR_W'(n_q);
            macc_q  <= '0;
            mcnt_q  <= MCW'(CURR_W);
            state_q <= S_MULT;
          end
        end
        S_DIVA: begin
          if (!div_busy) begin
            avg_q   <= div_quot[PW-1:0];
            state_q <= S_EVAL;
          end
        end
        S_EVAL: begin
          cnt_q[p_q]    <= ev_cnt;
          filled_q[p_q] <= ev_fil;
          load_q[p_q]   <= ev_ld;
          res_cyc_q     <= ev_cyc;
          res_dis_q     <= ev_dis;
          res_ena_q     <= ev_ena;
          res_load_q    <= ev_ld;
          res_full_q    <= ev_fil;
          state_q       <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            o_port_q    <= port_q;
            o_pw_q      <= pw_q;
            o_avg_q     <= on_q ? avg_q : '0;
            o_rec_q     <= rec_valid_q ? rec_avg_q : '0;
            o_cyc_q     <= res_cyc_q;
            o_dis_q     <= res_dis_q;
            o_ena_q     <= res_ena_q;
            o_load_q    <= res_load_q;
            o_full_q    <= res_full_q;
            o_recv_q    <= rec_valid_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.port_out        = o_port_q;
  assign out_o.power_mw        = o_pw_q;
  assign out_o.average_mw      = o_avg_q;
  assign out_o.power_cycle     = o_cyc_q;
  assign out_o.disable_request = o_dis_q;
  assign out_o.enable_request  = o_ena_q;
  assign out_o.load_present    = o_load_q;
  assign out_o.window_full     = o_full_q;
  assign out_o.record_valid    = o_recv_q;
  assign out_o.record_avg_mw   = o_rec_q;

  a_cycle_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.power_cycle |-> !out_o.load_present && !out_o.window_full)
    else $error("Power cycle beat left load or full flag set.");

  a_req_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.enable_request && out_o.disable_request))
    else $error("Enable and disable requested together.");

  a_rec_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.record_valid |-> out_o.record_avg_mw == '0)
    else $error("Record average shown without a completed record.");

  a_idle_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !div_busy)
    else $error("Divider busy while a new sample may be taken.");
endmodule
